// ===== hdl/fbd_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths and constants for the fractional baud divider calculator.
// No dependencies.
package fbd_pkg;

  localparam int unsigned BAUD_W = 24;
  localparam int unsigned MHZ_W = 8;
  localparam int unsigned SCLK_W = 28;
  localparam int unsigned HZ_W = 20;
  localparam logic [HZ_W-1:0] HZ_PER_MHZ = HZ_W'(1000000);
  localparam logic [MHZ_W-1:0] MHZ_RESET = MHZ_W'(40);
  localparam int unsigned FRAC_BITS = 4;
  localparam int unsigned INT_FIELD_W = 12;
  localparam int unsigned PRE_FIELD_W = 8;
  localparam int unsigned IN_TDATA_W = 24;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned INT_DIV_BITS_DEF = 12;
  localparam int unsigned PRESCALE_BITS_DEF = 8;

endpackage

// ===== hdl/fractional_baud_divider_calc.sv =====
`timescale 1ns / 1ps
// Fractional baud divider calculator; two bit-serial divider pipelines set the depth.
// Throughput is one item per cycle while the output register is not stalled.
// The whole pipeline stalls together only when the output register holds an untaken item.
// Reset clears all valid bits and sets the source clock register to 40 MHz.
module fractional_baud_divider_calc
  import fbd_pkg::*;
#(
  parameter int unsigned INT_DIV_BITS = INT_DIV_BITS_DEF,
  parameter int unsigned PRESCALE_BITS = PRESCALE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [MHZ_W-1:0]       cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [23:0] baud_rate
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [11:0] divider_integer, [15:12] divider_fraction, [23:16] prescale_field,
  // [24] prescale_clamped, [25] integer_truncated, rest zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned CMP_W = BAUD_W + 1 + INT_DIV_BITS;
  localparam int unsigned PRE_W = PRESCALE_BITS + 1;
  localparam int unsigned PROD_W = BAUD_W + PRE_W;
  localparam int unsigned SIX_W = SCLK_W + FRAC_BITS;
  localparam int unsigned WHOLE_W = SIX_W - FRAC_BITS;
  localparam logic [INT_DIV_BITS-1:0] INT_MAX = '1;
  localparam logic [PRE_W-1:0] PRE_MAX = PRE_W'(1) << PRESCALE_BITS;
  localparam int unsigned QN_W = PRESCALE_BITS + INT_DIV_BITS + 1;
  localparam int unsigned RCP_SH = PRESCALE_BITS + 2 * INT_DIV_BITS + 1;
  localparam int unsigned RCP_W = PRESCALE_BITS + INT_DIV_BITS + 2;
  localparam int unsigned RPROD_W = QN_W + RCP_W;
  localparam longint unsigned INT_MAX_L = (64'd1 << INT_DIV_BITS) - 64'd1;
  localparam longint unsigned PRE_LIM = (64'd1 << PRESCALE_BITS) * INT_MAX_L;
  localparam logic [RCP_W-1:0] RCP =
    RCP_W'(((64'd1 << RCP_SH) + INT_MAX_L - 64'd1) / INT_MAX_L);

  typedef struct packed {
    logic [BAUD_W-1:0] baud;
    logic [SCLK_W-1:0] sclk;
    logic              cond;
  } side_a_t;

  typedef struct packed {
    logic [PRE_W-1:0] pre;
    logic             clamped;
  } side_b_t;

  logic              en;
  logic [MHZ_W-1:0]  mhz_q;
  logic              v0_q, v1_q, v2_q, vr_q, v3_q, v4_q, out_v_q;
  logic [BAUD_W-1:0] baud0_q, baud1_q;
  logic [SCLK_W-1:0] sclk0_q, sclk1_q;
  logic              cond1_q;
  logic [BAUD_W-1:0] baud_in;
  logic [CMP_W-1:0]  cmp_prod;

  logic              d1_valid;
  logic [SCLK_W-1:0] d1_quot;
  side_a_t           d1_side_in, d1_side;

  logic [QN_W-1:0]    num2_q;
  logic               over2_q;
  side_a_t            side2_q;
  logic [RPROD_W-1:0] rcp_q;
  logic               overr_q;
  side_a_t            sider_q;

  logic [PRE_W-1:0]  pre3_q;
  logic              clamped3_q;
  logic [BAUD_W-1:0] baud3_q;
  logic [SCLK_W-1:0] sclk3_q;

  logic [PROD_W-1:0] prod4_q;
  logic [SIX_W-1:0]  dvd4_q;
  side_b_t           side4_q;
  logic              d3_valid;
  logic [SIX_W-1:0]  d3_quot;
  side_b_t           d3_side;

  logic [WHOLE_W-1:0]     whole;
  logic [PRE_W-1:0]       pre_m1;
  logic [OUT_TDATA_W-1:0] out_d, out_q;

  assign en = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mhz_q <= MHZ_RESET;
    end else if (cfg_we_i) begin
      mhz_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q    <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      vr_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v0_q    <= s_axis_tvalid;
      v1_q    <= v0_q;
      v2_q    <= d1_valid;
      vr_q    <= v2_q;
      v3_q    <= vr_q;
      v4_q    <= v3_q;
      out_v_q <= d3_valid;
    end
  end

  assign baud_in  = (s_axis_tdata[BAUD_W-1:0] == '0) ? BAUD_W'(1) : s_axis_tdata[BAUD_W-1:0];
  assign cmp_prod = CMP_W'({1'b0, baud0_q} + (BAUD_W + 1)'(1)) * CMP_W'(INT_MAX);

  always_ff @(posedge clk_i) begin
    if (en) begin
      baud0_q <= baud_in;
      sclk0_q <= SCLK_W'(mhz_q * HZ_PER_MHZ);
      baud1_q <= baud0_q;
      sclk1_q <= sclk0_q;
      cond1_q <= cmp_prod <= CMP_W'(sclk0_q);
    end
  end

  assign d1_side_in = '{baud: baud1_q, sclk: sclk1_q, cond: cond1_q};

  fbd_divider #(
    .DVD_W (SCLK_W),
    .DVS_W (BAUD_W),
    .SIDE_W($bits(side_a_t))
  ) u_div_sclk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (v1_q),
    .dividend_i(sclk1_q),
    .divisor_i (baud1_q),
    .side_i    (d1_side_in),
    .valid_o   (d1_valid),
    .quotient_o(d1_quot),
    .side_o    (d1_side)
  );

  // The rounded-up division by the integer field maximum uses a reciprocal multiplication.
  always_ff @(posedge clk_i) begin
    if (en) begin
      num2_q  <= QN_W'(d1_quot) + QN_W'(INT_MAX - INT_DIV_BITS'(1));
      over2_q <= d1_side.cond && (64'(d1_quot) > PRE_LIM);
      side2_q <= d1_side;
      rcp_q   <= RPROD_W'(num2_q) * RPROD_W'(RCP);
      overr_q <= over2_q;
      sider_q <= side2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (overr_q) begin
        pre3_q <= PRE_MAX;
      end else if (sider_q.cond) begin
        pre3_q <= rcp_q[RCP_SH +: PRE_W];
      end else begin
        pre3_q <= PRE_W'(1);
      end
      clamped3_q <= overr_q;
      baud3_q    <= sider_q.baud;
      sclk3_q    <= sider_q.sclk;
      prod4_q    <= PROD_W'(baud3_q) * PROD_W'(pre3_q);
      dvd4_q     <= {sclk3_q, FRAC_BITS'(0)};
      side4_q    <= '{pre: pre3_q, clamped: clamped3_q};
    end
  end

  fbd_divider #(
    .DVD_W (SIX_W),
    .DVS_W (PROD_W),
    .SIDE_W($bits(side_b_t))
  ) u_div_six (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (v4_q),
    .dividend_i(dvd4_q),
    .divisor_i (prod4_q),
    .side_i    (side4_q),
    .valid_o   (d3_valid),
    .quotient_o(d3_quot),
    .side_o    (d3_side)
  );

  assign whole  = d3_quot[SIX_W-1:FRAC_BITS];
  assign pre_m1 = d3_side.pre - PRE_W'(1);

  always_comb begin
    out_d = '0;
    out_d[11:0]  = INT_FIELD_W'(whole[INT_DIV_BITS-1:0]);
    out_d[15:12] = d3_quot[FRAC_BITS-1:0];
    out_d[23:16] = PRE_FIELD_W'(pre_m1);
    out_d[24]    = d3_side.clamped;
    out_d[25]    = whole > WHOLE_W'(INT_MAX);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");

  a_clamp_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[24]) |->
      (m_axis_tdata[23:16] == PRE_FIELD_W'(PRE_MAX - PRE_W'(1))))
    else $error("clamped prescale is not at field maximum");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && !en) |=> v4_q)
    else $error("item lost in a stalled stage");

endmodule

// ===== hdl/fbd_divider.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per register stage.
// Carries a sideband vector alongside each item; uses fbd_pkg.
module fbd_divider
  import fbd_pkg::*;
#(
  parameter int unsigned DVD_W = 8,
  parameter int unsigned DVS_W = 8,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [DVD_W-1:0]  dividend_i,
  input  logic [DVS_W-1:0]  divisor_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [DVD_W-1:0]  quotient_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              valid_q [DVD_W];
  logic [DVS_W-1:0]  rem_q   [DVD_W];
  logic [DVD_W-1:0]  qd_q    [DVD_W];
  logic [DVS_W-1:0]  dvs_q   [DVD_W];
  logic [SIDE_W-1:0] side_q  [DVD_W];

  for (genvar k = 0; k < DVD_W; k++) begin : g_stage
    logic              in_valid;
    logic [DVS_W-1:0]  in_rem;
    logic [DVD_W-1:0]  in_qd;
    logic [DVS_W-1:0]  in_dvs;
    logic [SIDE_W-1:0] in_side;
    logic [DVS_W:0]    rem_sh;
    logic [DVS_W:0]    rem_sub;
    logic              ge;

    if (k == 0) begin : g_first
      assign in_valid = valid_i;
      assign in_rem   = '0;
      assign in_qd    = dividend_i;
      assign in_dvs   = divisor_i;
      assign in_side  = side_i;
    end else begin : g_next
      assign in_valid = valid_q[k-1];
      assign in_rem   = rem_q[k-1];
      assign in_qd    = qd_q[k-1];
      assign in_dvs   = dvs_q[k-1];
      assign in_side  = side_q[k-1];
    end

    assign rem_sh  = {in_rem, in_qd[DVD_W-1]};
    assign ge      = rem_sh >= {1'b0, in_dvs};
    assign rem_sub = ge ? (rem_sh - {1'b0, in_dvs}) : rem_sh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= in_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_sub[DVS_W-1:0];
        qd_q[k]   <= {in_qd[DVD_W-2:0], ge};
        dvs_q[k]  <= in_dvs;
        side_q[k] <= in_side;
      end
    end
  end

  assign valid_o    = valid_q[DVD_W-1];
  assign quotient_o = qd_q[DVD_W-1];
  assign side_o     = side_q[DVD_W-1];

endmodule
